@@ src/band_stereo_correlation_meter_top_defines.svh @@
// Assertion macros for the band stereo correlation meter.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BAND_STEREO_CORRELATION_METER_TOP_DEFINES_SVH
`define BAND_STEREO_CORRELATION_METER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BSCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BSCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bscm_pkg.sv @@
// Shared types and constants of the band stereo correlation meter.
// No dependencies.
package bscm_pkg;

	localparam int DEF_MAX_BANDS   = 128;
	localparam int DEF_SAMPLE_BITS = 18;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int WGT_W  = 17;
	localparam int BAND_W = 7;
	localparam int THR_W  = 62;
	localparam int COEF_W = 16;

	localparam logic [WGT_W-1:0]  ONE_Q16     = 17'd65536;
	localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd32768;
	localparam logic [COEF_W-1:0] RELEASE_RST = 16'd6554;

	typedef enum logic [1:0] {
		REG_OPEN,
		REG_CLOSE,
		REG_ATTACK,
		REG_RELEASE
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ,
		ST_WT,
		ST_ACC,
		ST_GATE,
		ST_SQX,
		ST_SQY,
		ST_MUL,
		ST_CSET,
		ST_CDIV,
		ST_WSET,
		ST_WDIV,
		ST_WSQ,
		ST_SMUL,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] op;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

endpackage

@@ src/bscm_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module bscm_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ src/bscm_isqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on bscm_pkg.
module bscm_isqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bscm_pkg::sqrt_req_t  req,
	output bscm_pkg::sqrt_rsp_t  rsp
);
	import bscm_pkg::*;

	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        take;

	assign trial = res_q + bit_q;
	assign take  = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.op;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (take) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q[31:0];

endmodule

@@ src/band_stereo_correlation_meter_top.sv @@
// Per-band stereo phase correlation meter: accumulation, gate, correlation and smoothing.
// Depends on bscm_pkg, bscm_ram, bscm_isqrt and the assertion macro header.
//
// Each bin item passes capture, square, weight and accumulate states; in_ready is low
// meanwhile. An item with band_end adds the band back end, at most: two 32-step square
// roots and a third for the width on the shared root unit, a 15-step correlation
// divide and a 30-step width divide on the shared divider, and gate, multiply, setup,
// smoothing and output states. A closed gate or a zero power skips the roots and
// divides. After reset, a clearing pass over all MAX_BANDS entries zeroes the per-band
// memory before the first item is taken; configuration writes are taken throughout. A
// finished result waits in the output register while the next bins are accumulated.
`include "band_stereo_correlation_meter_top_defines.svh"

module band_stereo_correlation_meter_top #(
	parameter int MAX_BANDS   = bscm_pkg::DEF_MAX_BANDS,
	parameter int SAMPLE_BITS = bscm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bscm_pkg::ADDR_W-1:0]       paddr,
	input  logic [bscm_pkg::DATA_W-1:0]       pwdata,
	output logic [bscm_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     left_re,
	input  logic signed [SAMPLE_BITS-1:0]     left_im,
	input  logic signed [SAMPLE_BITS-1:0]     right_re,
	input  logic signed [SAMPLE_BITS-1:0]     right_im,
	input  logic [bscm_pkg::WGT_W-1:0]        bin_weight,
	input  logic [bscm_pkg::BAND_W-1:0]       band_index,
	input  logic                              band_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bscm_pkg::BAND_W-1:0]       out_band,
	output logic signed [15:0]                smoothed_corr,
	output logic [7:0]                        colour_index,
	output logic [15:0]                       width_ratio,
	output logic                              gate_open
);
	import bscm_pkg::*;

	localparam int AW   = $clog2(MAX_BANDS);
	localparam int ML_W = 2 * SAMPLE_BITS;
	localparam int CR_W = 2 * SAMPLE_BITS + 1;
	localparam int PW   = ML_W + WGT_W;

	// configuration
	logic [THR_W-1:0]  open_q, close_q;
	logic [COEF_W-1:0] attack_q, release_q;
	reg_idx_t          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= '0;
			close_q   <= '0;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_OPEN:    open_q    <= pwdata[THR_W-1:0];
				REG_CLOSE:   close_q   <= pwdata[THR_W-1:0];
				REG_ATTACK:  attack_q  <= pwdata[COEF_W-1:0];
				REG_RELEASE: release_q <= pwdata[COEF_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OPEN:    prdata = DATA_W'(open_q);
			REG_CLOSE:   prdata = DATA_W'(close_q);
			REG_ATTACK:  prdata = DATA_W'(attack_q);
			REG_RELEASE: prdata = DATA_W'(release_q);
		endcase
	end

	// control
	state_t state_q, state_d;
	logic [AW-1:0] clr_q;

	// bin pipeline
	logic signed [SAMPLE_BITS-1:0] lr_s1, li_s1, rr_s1, ri_s1;
	logic [WGT_W-1:0]              w_s1;
	logic [BAND_W-1:0]             band_s1;
	logic                          end_s1;
	logic [ML_W-1:0]               ml_s2, mr_s2;
	logic signed [CR_W-1:0]        cr_s2;
	logic [PW-1:0]                 pl_s3, pr_s3, pc_s3;
	logic                          cneg_s3;

	logic [63:0]        accl_q, accr_q;
	logic signed [63:0] accc_q;
	logic [63:0]        sx_q, sy_q;
	logic signed [63:0] sxy_q;

	logic signed [ML_W-1:0] p_ll, p_li, p_rr, p_ri, p_x1, p_x2;
	logic [ML_W-1:0]        cmag;
	logic [65:0]            sum_l, sum_r;
	logic signed [65:0]     sum_c, accc_ext, pc_ext;
	logic [63:0]            accl_nx, accr_nx;
	logic signed [63:0]     accc_nx;

	// band back end
	logic [10:0]        band_ext;
	logic [AW-1:0]      band_lo;
	logic               inrange;
	logic               inrange_q, gate_q, neg_q;
	logic signed [15:0] y_q, r_q, yn_q;
	logic [15:0]        width_q;
	logic [31:0]        sqx_q, sqy_q;
	logic [63:0]        den_q, mag_q;
	logic [63:0]        energy;
	logic               gate_nx, calc;

	logic [63:0] rem_q, dden_q, rem_nx;
	logic [29:0] num_q, quo_q, quo_nx;
	logic [4:0]  cnt_q;
	logic [64:0] r2;
	logic        ge, wide;

	logic signed [33:0] prod_q;
	logic signed [33:0] prod_rnd;
	logic signed [17:0] corr_step;
	logic signed [18:0] yn_wide;
	logic signed [15:0] yn;
	logic [15:0]        abs_r, abs_y;
	logic [COEF_W-1:0]  coef;
	logic signed [16:0] diff;

	logic [14:0]  abs_yn;
	logic [19:0]  dz;
	logic [15:0]  shifted;
	logic [23:0]  colour_full;

	logic               out_valid_q, out_gate_q;
	logic [BAND_W-1:0]  out_band_q;
	logic signed [15:0] out_corr_q;
	logic [7:0]         out_colour_q;
	logic [15:0]        out_width_q;

	// memory: {gate, smoothed} per band
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [16:0]   ram_wdata, ram_rdata;

	sqrt_req_t sreq;
	sqrt_rsp_t srsp;

	bscm_ram #(.WIDTH(17), .DEPTH(MAX_BANDS)) u_band_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bscm_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	// squares and cross products
	assign p_ll = lr_s1 * lr_s1;
	assign p_li = li_s1 * li_s1;
	assign p_rr = rr_s1 * rr_s1;
	assign p_ri = ri_s1 * ri_s1;
	assign p_x1 = lr_s1 * rr_s1;
	assign p_x2 = li_s1 * ri_s1;
	assign cmag = cr_s2[CR_W-1] ? ML_W'(-cr_s2) : ML_W'(cr_s2);

	// saturating accumulation
	assign sum_l    = {2'b00, accl_q} + 66'(pl_s3);
	assign sum_r    = {2'b00, accr_q} + 66'(pr_s3);
	assign accc_ext = 66'(accc_q);
	assign pc_ext   = $signed(66'(pc_s3));
	assign sum_c    = cneg_s3 ? accc_ext - pc_ext : accc_ext + pc_ext;
	assign accl_nx  = (sum_l[65:64] != 2'b00) ? '1 : sum_l[63:0];
	assign accr_nx  = (sum_r[65:64] != 2'b00) ? '1 : sum_r[63:0];

	always_comb begin
		if (sum_c[65:63] == 3'b000 || sum_c[65:63] == 3'b111) begin
			accc_nx = sum_c[63:0];
		end else if (sum_c[65]) begin
			accc_nx = {1'b1, 63'd0};
		end else begin
			accc_nx = {1'b0, {63{1'b1}}};
		end
	end

	// gate
	assign band_ext = 11'(band_s1);
	assign band_lo  = band_ext[AW-1:0];
	assign inrange  = band_ext < 11'(MAX_BANDS);
	assign energy   = (sx_q >> 1) + (sy_q >> 1) + 64'(sx_q[0] & sy_q[0]);
	assign gate_nx  = (inrange && ram_rdata[16]) ? (energy > 64'(close_q))
	                                             : (energy > 64'(open_q));
	assign calc     = gate_nx && (sx_q != '0) && (sy_q != '0);

	// shared restoring divider step
	assign r2     = {rem_q, num_q[29]};
	assign ge     = r2 >= {1'b0, dden_q};
	assign rem_nx = ge ? 64'(r2 - {1'b0, dden_q}) : r2[63:0];
	assign quo_nx = {quo_q[28:0], ge};
	assign wide   = {2'b00, sy_q} >= {sx_q, 2'b00};

	// smoothing
	assign abs_r     = r_q[15] ? 16'(-r_q) : 16'(r_q);
	assign abs_y     = y_q[15] ? 16'(-y_q) : 16'(y_q);
	assign coef      = (abs_r > abs_y) ? attack_q : release_q;
	assign diff      = 17'(r_q) - 17'(y_q);
	assign prod_rnd  = prod_q + 34'sd32768;
	assign corr_step = prod_rnd[33:16];
	assign yn_wide   = 19'(y_q) + 19'(corr_step);

	always_comb begin
		if (yn_wide > 19'sd32767) begin
			yn = 16'sd32767;
		end else if (yn_wide < -19'sd32767) begin
			yn = -16'sd32767;
		end else begin
			yn = yn_wide[15:0];
		end
	end

	// colour with dead zone
	assign abs_yn      = yn_q[15] ? 15'(-yn_q) : yn_q[14:0];
	assign dz          = 20'(abs_yn) * 20'd25;
	assign shifted     = (dz < 20'd32768) ? 16'd32768 : 16'(yn_q) + 16'd32768;
	assign colour_full = 24'(shifted) * 24'd255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		sreq      = '0;
		ram_we    = 1'b0;
		ram_addr  = band_lo;
		ram_wdata = {gate_q, yn};
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_addr  = clr_q;
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (clr_q == AW'(MAX_BANDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:  state_d = ST_WT;
			ST_WT:  state_d = ST_ACC;
			ST_ACC: state_d = end_s1 ? ST_GATE : ST_IDLE;
			ST_GATE: begin
				if (calc) begin
					sreq.start = 1'b1;
					sreq.op    = sx_q;
					state_d    = ST_SQX;
				end else begin
					state_d = ST_SMUL;
				end
			end
			ST_SQX: begin
				if (srsp.done) begin
					sreq.start = 1'b1;
					sreq.op    = sy_q;
					state_d    = ST_SQY;
				end
			end
			ST_SQY: begin
				if (srsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_CSET;
			ST_CSET: state_d = (mag_q >= den_q) ? ST_WSET : ST_CDIV;
			ST_CDIV: begin
				if (cnt_q == 5'd1) begin
					state_d = ST_WSET;
				end
			end
			ST_WSET: state_d = wide ? ST_SMUL : ST_WDIV;
			ST_WDIV: begin
				if (cnt_q == 5'd1) begin
					sreq.start = 1'b1;
					sreq.op    = 64'(quo_nx);
					state_d    = ST_WSQ;
				end
			end
			ST_WSQ: begin
				if (srsp.done) begin
					state_d = ST_SMUL;
				end
			end
			ST_SMUL: state_d = ST_FIN;
			ST_FIN: begin
				ram_we  = inrange_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accl_q <= '0;
			accr_q <= '0;
			accc_q <= '0;
		end else if (state_q == ST_ACC) begin
			if (end_s1) begin
				accl_q <= '0;
				accr_q <= '0;
				accc_q <= '0;
			end else begin
				accl_q <= accl_nx;
				accr_q <= accr_nx;
				accc_q <= accc_nx;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					lr_s1   <= left_re;
					li_s1   <= left_im;
					rr_s1   <= right_re;
					ri_s1   <= right_im;
					w_s1    <= (bin_weight > ONE_Q16) ? ONE_Q16 : bin_weight;
					band_s1 <= band_index;
					end_s1  <= band_end;
				end
			end
			ST_SQ: begin
				ml_s2 <= ML_W'(p_ll) + ML_W'(p_li);
				mr_s2 <= ML_W'(p_rr) + ML_W'(p_ri);
				cr_s2 <= CR_W'(p_x1) + CR_W'(p_x2);
			end
			ST_WT: begin
				pl_s3   <= PW'(ml_s2) * PW'(w_s1);
				pr_s3   <= PW'(mr_s2) * PW'(w_s1);
				pc_s3   <= PW'(cmag) * PW'(w_s1);
				cneg_s3 <= cr_s2[CR_W-1];
			end
			ST_ACC: begin
				sx_q  <= accl_nx;
				sy_q  <= accr_nx;
				sxy_q <= accc_nx;
			end
			ST_GATE: begin
				inrange_q <= inrange;
				gate_q    <= gate_nx;
				y_q       <= inrange ? $signed(ram_rdata[15:0]) : 16'sd0;
				r_q       <= '0;
				width_q   <= '0;
				neg_q     <= sxy_q[63];
				mag_q     <= sxy_q[63] ? 64'd0 - 64'(sxy_q) : 64'(sxy_q);
			end
			ST_SQX: begin
				if (srsp.done) begin
					sqx_q <= srsp.root;
				end
			end
			ST_SQY: begin
				if (srsp.done) begin
					sqy_q <= srsp.root;
				end
			end
			ST_MUL: den_q <= 64'(sqx_q) * 64'(sqy_q);
			ST_CSET: begin
				if (mag_q >= den_q) begin
					r_q <= neg_q ? -16'sd32767 : 16'sd32767;
				end else begin
					rem_q  <= mag_q;
					dden_q <= den_q;
					num_q  <= '0;
					quo_q  <= '0;
					cnt_q  <= 5'd15;
				end
			end
			ST_CDIV, ST_WDIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 5'd1;
				if (state_q == ST_CDIV && cnt_q == 5'd1) begin
					r_q <= neg_q ? -$signed({1'b0, quo_nx[14:0]})
					             : $signed({1'b0, quo_nx[14:0]});
				end
			end
			ST_WSET: begin
				if (wide) begin
					width_q <= 16'd32768;
				end else begin
					rem_q  <= sy_q >> 2;
					dden_q <= sx_q;
					num_q  <= {sy_q[1:0], 28'd0};
					quo_q  <= '0;
					cnt_q  <= 5'd30;
				end
			end
			ST_WSQ: begin
				if (srsp.done) begin
					width_q <= srsp.root[15:0];
				end
			end
			ST_SMUL: prod_q <= $signed({1'b0, coef}) * diff;
			ST_FIN:  yn_q <= yn;
			default: ;
		endcase
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_band_q   <= band_s1;
			out_corr_q   <= yn_q;
			out_colour_q <= colour_full[23:16];
			out_width_q  <= width_q;
			out_gate_q   <= gate_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_band      = out_band_q;
	assign smoothed_corr = out_corr_q;
	assign colour_index  = out_colour_q;
	assign width_ratio   = out_width_q;
	assign gate_open     = out_gate_q;

	`BSCM_ASSERT_IMP(a_corr_range, out_valid, smoothed_corr != 16'sh8000, "correlation out of range")
	`BSCM_ASSERT_IMP(a_width_range, out_valid, width_ratio <= 16'd32768, "width out of range")
	`BSCM_ASSERT_IMP(a_closed_width, out_valid && !gate_open, width_ratio == 16'd0, "width on closed gate")
	`BSCM_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")

endmodule

@@ tb/band_stereo_correlation_meter_checker.sv @@
// Checker for the band stereo correlation meter: watches the config port and both item
// channels, predicts each band result and compares it with what the block returns.
// Depends on bscm_pkg.
`timescale 1ns / 100ps

module band_stereo_correlation_meter_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bscm_pkg::ADDR_W-1:0] paddr,
	input  logic [bscm_pkg::DATA_W-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [17:0]          left_re,
	input  logic signed [17:0]          left_im,
	input  logic signed [17:0]          right_re,
	input  logic signed [17:0]          right_im,
	input  logic [16:0]                 bin_weight,
	input  logic [6:0]                  band_index,
	input  logic                        band_end,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [6:0]                  out_band,
	input  logic signed [15:0]          smoothed_corr,
	input  logic [7:0]                  colour_index,
	input  logic [15:0]                 width_ratio,
	input  logic                        gate_open,
	output int                          fails,
	output int                          pending
);
	import bscm_pkg::*;

	localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint S64_MIN = -S64_MAX - 1;

	typedef struct {
		logic [6:0]         band;
		logic signed [15:0] corr;
		logic [7:0]         colour;
		logic [15:0]        width;
		logic               gate;
	} band_result_t;

	band_result_t band_results_q[$];

	longint unsigned open_thr, close_thr;
	longint          attack_k, release_k;
	longint unsigned left_pow, right_pow;
	longint          cross_pow;
	longint          smooth_mem[128];
	logic            gate_mem[128];

	assign pending = band_results_q.size();

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic meter_step(input logic signed [17:0] lre, lim, rre, rim,
			input logic [16:0] wt, input logic [6:0] bd, input logic last);
		longint lr, li, rr, ri, cr, sxy, r, y, yn, dz, a, ar, ay;
		longint unsigned w, ml, mr, cmag, sx, sy, den, mag, q, en, colour;
		logic [64:0] usum;
		logic signed [66:0] ssum;
		logic [127:0] wide;
		logic gate;
		logic [15:0] wr;
		band_result_t res;
		lr = 64'(lre);
		li = 64'(lim);
		rr = 64'(rre);
		ri = 64'(rim);
		w = (wt > ONE_Q16) ? 64'(ONE_Q16) : 64'(wt);
		ml = lr * lr + li * li;
		mr = rr * rr + ri * ri;
		cr = lr * rr + li * ri;
		cmag = (cr < 0) ? -cr : cr;
		usum = {1'b0, left_pow} + ml * w;
		left_pow = usum[64] ? '1 : usum[63:0];
		usum = {1'b0, right_pow} + mr * w;
		right_pow = usum[64] ? '1 : usum[63:0];
		ssum = 67'(cross_pow);
		if (cr < 0)
			ssum = ssum - $signed({3'b000, cmag * w});
		else
			ssum = ssum + $signed({3'b000, cmag * w});
		if (ssum > S64_MAX)
			cross_pow = S64_MAX;
		else if (ssum < S64_MIN)
			cross_pow = S64_MIN;
		else
			cross_pow = ssum[63:0];
		if (!last)
			return;

		sx = left_pow;
		sy = right_pow;
		sxy = cross_pow;
		left_pow = 0;
		right_pow = 0;
		cross_pow = 0;
		y = smooth_mem[bd];
		usum = {1'b0, sx} + sy;
		en = usum[64:1];
		gate = gate_mem[bd] ? (en > close_thr) : (en > open_thr);
		r = 0;
		wr = 0;
		if (gate && sx != 0 && sy != 0) begin
			den = root64(sx) * root64(sy);
			mag = (sxy < 0) ? (64'd0 - sxy) : sxy;
			if (mag >= den) begin
				q = 32767;
			end else begin
				wide = {64'd0, mag} << 15;
				q = 64'(wide / den);
			end
			r = q;
			if (sxy < 0)
				r = -r;
			if (sy / sx >= 4) begin
				wr = 16'd32768;
			end else begin
				wide = {64'd0, sy} << 28;
				wr = 16'(root64(64'(wide / sx)));
			end
		end
		ar = (r < 0) ? -r : r;
		ay = (y < 0) ? -y : y;
		a = (ar > ay) ? attack_k : release_k;
		yn = y + ((a * (r - y) + 32768) >>> 16);
		if (yn > 32767)
			yn = 32767;
		if (yn < -32767)
			yn = -32767;
		smooth_mem[bd] = yn;
		gate_mem[bd] = gate;
		// dead zone around zero before mapping to the palette
		dz = (((yn < 0) ? -yn : yn) * 25 < 32768) ? 0 : yn;
		colour = ((dz + 32768) * 255) >> 16;
		if (colour > 255)
			colour = 255;
		res.band = bd;
		res.corr = 16'(yn);
		res.colour = 8'(colour);
		res.width = wr;
		res.gate = gate;
		band_results_q = {band_results_q, res};
	endtask

	always @(posedge clk or negedge arst_n) begin
		band_result_t exp_r;
		if (!arst_n) begin
			open_thr = 0;
			close_thr = 0;
			attack_k = 64'(ATTACK_RST);
			release_k = 64'(RELEASE_RST);
			left_pow = 0;
			right_pow = 0;
			cross_pow = 0;
			foreach (smooth_mem[i]) begin
				smooth_mem[i] = 0;
				gate_mem[i] = 1'b0;
			end
			band_results_q.delete();
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:3]))
					REG_OPEN:    open_thr = 64'(pwdata[61:0]);
					REG_CLOSE:   close_thr = 64'(pwdata[61:0]);
					REG_ATTACK:  attack_k = 64'(pwdata[15:0]);
					REG_RELEASE: release_k = 64'(pwdata[15:0]);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (band_results_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result for band %0d", $realtime, out_band);
				end else begin
					exp_r = band_results_q.pop_front();
					if (exp_r.band !== out_band || exp_r.corr !== smoothed_corr ||
							exp_r.colour !== colour_index || exp_r.width !== width_ratio ||
							exp_r.gate !== gate_open) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch exp band %0d corr %0d colour %0d", $realtime,
								exp_r.band, exp_r.corr, exp_r.colour,
								" width %0d gate %0d, got band %0d corr %0d", exp_r.width,
								exp_r.gate, out_band, smoothed_corr,
								" colour %0d width %0d gate %0d", colour_index, width_ratio,
								gate_open);
					end
				end
			end
			if (in_valid && in_ready)
				meter_step(left_re, left_im, right_re, right_im, bin_weight, band_index,
					band_end);
		end
	end

endmodule

@@ tb/band_stereo_correlation_meter_top_tb.sv @@
// Testbench top for the band stereo correlation meter: clock, reset, config writes,
// bin stimulus and the verdict. Depends on bscm_pkg, the block and the checker module.
`timescale 1ns / 100ps

module band_stereo_correlation_meter_top_tb;
	import bscm_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam logic signed [17:0] S18_MAX = 18'sd131071;
	localparam logic signed [17:0] S18_MIN = -18'sd131071 - 18'sd1;
	localparam longint unsigned THR_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic signed [17:0] left_re = '0, left_im = '0, right_re = '0, right_im = '0;
	logic [16:0]       bin_weight = '0;
	logic [6:0]        band_index = '0;
	logic              band_end = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [6:0]        out_band;
	logic signed [15:0] smoothed_corr;
	logic [7:0]        colour_index;
	logic [15:0]       width_ratio;
	logic              gate_open;
	int                fails, pending;
	int                idle_cycles = 0;
	int                stall_left = 0;
	bit                calm = 1'b0;

	always #4 clk = ~clk;

	band_stereo_correlation_meter_top u_dut (.*);

	band_stereo_correlation_meter_checker u_chk (.*);

	// receiver: random stalls, none started while calm
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** band_stereo_correlation_meter_top: FAILED **");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		if (k < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [17:0] negate18(input logic signed [17:0] x);
		return (x == S18_MIN) ? S18_MAX : -x;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input longint unsigned val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_bin(input logic signed [17:0] lr, li, rr, ri,
			input logic [16:0] w, input logic [6:0] bd, input logic last);
		int g;
		g = pick_gap();
		in_valid <= 1'b1;
		left_re <= lr;
		left_im <= li;
		right_re <= rr;
		right_im <= ri;
		bin_weight <= w;
		band_index <= bd;
		band_end <= last;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// one band: every bin follows the same left/right relation
	task automatic send_band(input logic [6:0] bd, input int nbins);
		int mode, sh;
		logic signed [17:0] lr, li, rr, ri;
		logic [16:0] w;
		mode = $urandom_range(0, 6);
		sh = $urandom_range(0, 4);
		for (int i = 0; i < nbins; i++) begin
			lr = 18'($urandom);
			li = 18'($urandom);
			rr = 18'($urandom);
			ri = 18'($urandom);
			case (mode)
				1: begin rr = lr; ri = li; end
				2: begin rr = negate18(lr); ri = negate18(li); end
				3: begin rr = lr >>> sh; ri = li >>> sh; end
				4: begin lr = rr >>> (sh + 1); li = ri >>> (sh + 1); end
				5: begin
					if (sh[0]) begin lr = 0; li = 0; end
					else begin rr = 0; ri = 0; end
				end
				6: begin
					lr = 18'($signed($urandom_range(0, 16)) - 8);
					li = 18'($signed($urandom_range(0, 16)) - 8);
					rr = 18'($signed($urandom_range(0, 16)) - 8);
					ri = 18'($signed($urandom_range(0, 16)) - 8);
				end
				default: ;
			endcase
			w = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
			send_bin(lr, li, rr, ri, w, ($urandom_range(0, 3) == 0) ? 7'($urandom) : bd,
				i == nbins - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_items(input int count);
		int sent, n;
		logic [6:0] bd;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 29) == 0)
				calm = ~calm;
			if ($urandom_range(0, 9) == 0) begin
				// stray bin, ending a band at random
				send_bin(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
					17'($urandom), 7'($urandom), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
				bd = ($urandom_range(0, 2) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7));
				send_band(bd, n);
				sent += n;
			end
		end
		calm = 1'b0;
	endtask

	task automatic full_scale_band(input int nbins, input logic flip, input logic [6:0] bd);
		calm = 1'b1;
		for (int i = 0; i < nbins; i++)
			send_bin(S18_MIN, S18_MIN, flip ? S18_MAX : S18_MIN, flip ? S18_MAX : S18_MIN,
				ONE_Q16, bd, i == nbins - 1);
		calm = 1'b0;
	endtask

	initial begin
		longint unsigned thr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed bins under reset settings
		send_bin(S18_MAX, S18_MAX, S18_MAX, S18_MAX, ONE_Q16, 7'd0, 1'b1);
		send_bin(S18_MIN, S18_MIN, S18_MIN, S18_MIN, 17'h1FFFF, 7'd127, 1'b1);
		send_bin(S18_MAX, S18_MIN, S18_MIN, S18_MAX, ONE_Q16, 7'd1, 1'b1);
		send_bin(S18_MAX, 18'sd0, 18'sd0, S18_MAX, ONE_Q16, 7'd2, 1'b1);
		send_bin(18'sd0, 18'sd0, S18_MAX, S18_MIN, ONE_Q16, 7'd3, 1'b1);
		send_bin(S18_MAX, S18_MAX, 18'sd0, 18'sd0, ONE_Q16, 7'd4, 1'b1);
		send_bin(S18_MAX, S18_MAX, S18_MAX, S18_MAX, 17'd0, 7'd5, 1'b1);
		send_bin(18'sd1, 18'sd0, 18'sd1, 18'sd0, 17'd1, 7'd6, 1'b1);
		send_bin(18'sd100, 18'sd0, 18'sd1000, 18'sd0, ONE_Q16, 7'd7, 1'b1);
		send_bin(18'sd1000, 18'sd7, 18'sd100, -18'sd3, 17'd65537, 7'd7, 1'b0);
		send_bin(18'sd500, -18'sd9, 18'sd40, 18'sd2, 17'd30000, 7'd8, 1'b1);
		for (int i = 0; i < 8; i++)
			send_bin(S18_MAX, S18_MIN, S18_MAX, S18_MIN, ONE_Q16, 7'd9, 1'b1);
		for (int i = 0; i < 6; i++)
			send_bin(S18_MIN, S18_MAX, S18_MAX, S18_MIN, ONE_Q16, 7'd10, 1'b1);
		random_items(300);
		drain();

		// wide open gate, instant attack, frozen release; full-scale bins back to back
		reg_write(REG_OPEN, 64'd0);
		reg_write(REG_CLOSE, 64'd0);
		reg_write(REG_ATTACK, 64'hFFFF);
		reg_write(REG_RELEASE, 64'd0);
		full_scale_band(40, 1'b0, 7'd11);
		full_scale_band(30, 1'b1, 7'd12);
		random_items(200);
		drain();

		// gate never opens, release at full speed
		reg_write(REG_OPEN, THR_MAX);
		reg_write(REG_CLOSE, THR_MAX);
		reg_write(REG_ATTACK, 64'd0);
		reg_write(REG_RELEASE, 64'hFFFF);
		random_items(200);
		drain();

		for (int p = 0; p < 4; p++) begin
			thr = {$urandom, $urandom};
			thr = thr >> $urandom_range(14, 34);
			reg_write(REG_OPEN, thr);
			reg_write(REG_CLOSE, thr >> $urandom_range(0, 4));
			reg_write(REG_ATTACK, 64'($urandom_range(0, 65535)));
			reg_write(REG_RELEASE, 64'($urandom_range(0, 65535)));
			random_items(150);
			// hold off until every band result is back
			drain();
			random_items(140);
			drain();
		end

		if (fails == 0 && pending == 0) begin
			$display("** band_stereo_correlation_meter_top: PASSED **");
		end else begin
			$display("** band_stereo_correlation_meter_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ band_stereo_correlation_meter_top.f @@
+incdir+src
src/bscm_pkg.sv
src/bscm_ram.sv
src/bscm_isqrt.sv
src/band_stereo_correlation_meter_top.sv
tb/band_stereo_correlation_meter_checker.sv
tb/band_stereo_correlation_meter_top_tb.sv
